>>> src/ray_box_slab_test_unit_assert.svh
// Assertion macros for the ray/box slab test unit.
// No dependencies; the including module must provide clk and rst_n.
`ifndef RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// a implies c in the same cycle
`define RBST_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("rbst assertion failed");
// a implies c in the following cycle
`define RBST_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("rbst assertion failed");
`else
`define RBST_ASSERT_IMP(lbl, a, c)
`define RBST_ASSERT_NXT(lbl, a, c)
`endif
`endif

>>> src/rbst_pkg.sv
// Shared constants and types for the ray/box slab test unit.
// No dependencies.
package rbst_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int DIR_WIDTH   = 18;

  localparam int HALF_W = 31;
  localparam int TLIM_W = 31;
  localparam int EPS_W  = 17;
  localparam int CFG_W  = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_T_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_EPS = 2'd2;

  localparam logic [HALF_W-1:0] HALF_RESET = 31'd32768;
  localparam logic [TLIM_W-1:0] TLIM_RESET = 31'd65536000;
  localparam logic [EPS_W-1:0]  EPS_RESET  = 17'd1;

  // slab bounds, numerators
  localparam int LH_W  = ((COORD_WIDTH > HALF_W) ? COORD_WIDTH : HALF_W) + 2;
  localparam int NUM_W = LH_W + 1;

  // t values and quotient
  localparam int T_W = 32;
  localparam int STEP_BITS = 4;
  localparam int DIV_ITERS = T_W / STEP_BITS;
  localparam int DIV_LAT   = DIV_ITERS + 2;
  localparam int CMP_W = (NUM_W > DIR_WIDTH + FRAC_BITS) ? NUM_W : DIR_WIDTH + FRAC_BITS;

  localparam logic signed [T_W-1:0] T_SAT_HI = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_SAT_LO = {1'b1, {(T_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0] par;
    logic [2:0] outside;
  } side_t;

endpackage

>>> src/rbst_fx_div.sv
// Pipelined fixed-point divider: (num << FRAC_BITS) / den, truncated, saturated.
// Depends on rbst_pkg. Input register, DIV_ITERS division stages, saturation register; one word per cycle.
module rbst_fx_div (
  input  logic                                clk,
  input  logic signed [rbst_pkg::NUM_W-1:0]   in_num,
  input  logic signed [rbst_pkg::DIR_WIDTH-1:0] in_den,
  output logic signed [rbst_pkg::T_W-1:0]     out_t
);

  localparam int NW = rbst_pkg::NUM_W + rbst_pkg::FRAC_BITS;

  logic [rbst_pkg::DIR_WIDTH-1:0] rem_r   [0:rbst_pkg::DIV_ITERS-1];
  logic [rbst_pkg::DIR_WIDTH-1:0] den_r   [0:rbst_pkg::DIV_ITERS-1];
  logic [rbst_pkg::T_W-1:0]       wrk_r   [0:rbst_pkg::DIV_ITERS];
  logic                           neg_r   [0:rbst_pkg::DIV_ITERS];
  logic                           ovf_r   [0:rbst_pkg::DIV_ITERS];
  logic [rbst_pkg::DIR_WIDTH-1:0] rem_nxt [0:rbst_pkg::DIV_ITERS-1];
  logic [rbst_pkg::T_W-1:0]       wrk_nxt [0:rbst_pkg::DIV_ITERS-1];
  logic signed [rbst_pkg::T_W-1:0] t_r;

  logic [rbst_pkg::NUM_W-1:0]     mag;
  logic [rbst_pkg::DIR_WIDTH-1:0] dmag;
  logic [NW-1:0]                  nsh;
  logic                           ovf;

  // prep: magnitudes, sign, and quotient >= 2^32 test
  always_comb begin
    mag  = in_num[rbst_pkg::NUM_W-1] ? rbst_pkg::NUM_W'(-in_num) : rbst_pkg::NUM_W'(in_num);
    dmag = in_den[rbst_pkg::DIR_WIDTH-1] ? rbst_pkg::DIR_WIDTH'(-in_den)
                                         : rbst_pkg::DIR_WIDTH'(in_den);
    nsh  = NW'(mag) << rbst_pkg::FRAC_BITS;
    ovf  = rbst_pkg::CMP_W'(mag) >= (rbst_pkg::CMP_W'(dmag) << rbst_pkg::FRAC_BITS);
  end

  // restoring division, STEP_BITS quotient bits per stage
  always_comb begin
    logic [rbst_pkg::DIR_WIDTH-1:0] r_v;
    logic [rbst_pkg::T_W-1:0]       w_v;
    logic [rbst_pkg::DIR_WIDTH:0]   tr_v;
    for (int k = 0; k < rbst_pkg::DIV_ITERS; k++) begin
      r_v = rem_r[k];
      w_v = wrk_r[k];
      for (int s = 0; s < rbst_pkg::STEP_BITS; s++) begin
        tr_v = {r_v, w_v[rbst_pkg::T_W-1]};
        w_v  = {w_v[rbst_pkg::T_W-2:0], 1'b0};
        if (tr_v >= {1'b0, den_r[k]}) begin
          tr_v   = tr_v - {1'b0, den_r[k]};
          w_v[0] = 1'b1;
        end
        r_v = tr_v[rbst_pkg::DIR_WIDTH-1:0];
      end
      rem_nxt[k] = r_v;
      wrk_nxt[k] = w_v;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= rbst_pkg::DIR_WIDTH'(nsh >> rbst_pkg::T_W);
    wrk_r[0] <= nsh[rbst_pkg::T_W-1:0];
    den_r[0] <= dmag;
    neg_r[0] <= in_num[rbst_pkg::NUM_W-1] ^ in_den[rbst_pkg::DIR_WIDTH-1];
    ovf_r[0] <= ovf;
    for (int k = 0; k < rbst_pkg::DIV_ITERS; k++) begin
      wrk_r[k+1] <= wrk_nxt[k];
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
    for (int k = 0; k < rbst_pkg::DIV_ITERS - 1; k++) begin
      rem_r[k+1] <= rem_nxt[k];
      den_r[k+1] <= den_r[k];
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (ovf_r[rbst_pkg::DIV_ITERS]) begin
      t_r <= neg_r[rbst_pkg::DIV_ITERS] ? rbst_pkg::T_SAT_LO : rbst_pkg::T_SAT_HI;
    end else if (neg_r[rbst_pkg::DIV_ITERS]) begin
      if (wrk_r[rbst_pkg::DIV_ITERS][rbst_pkg::T_W-1]
          && (wrk_r[rbst_pkg::DIV_ITERS][rbst_pkg::T_W-2:0] != '0)) begin
        t_r <= rbst_pkg::T_SAT_LO;
      end else begin
        t_r <= -$signed(wrk_r[rbst_pkg::DIV_ITERS]);
      end
    end else if (wrk_r[rbst_pkg::DIV_ITERS][rbst_pkg::T_W-1]) begin
      t_r <= rbst_pkg::T_SAT_HI;
    end else begin
      t_r <= $signed(wrk_r[rbst_pkg::DIV_ITERS]);
    end
  end

  assign out_t = t_r;

endmodule

>>> src/ray_box_slab_test_unit.sv
// Top level of the ray/box slab test unit: input capture, slab bounds,
// six pipelined dividers, interval merge. Depends on rbst_pkg, rbst_fx_div.
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------
//  input   | start && !busy       | origin, direction, box centre (x,y,z)
//  result  | out_valid (1 cycle)  | hit, t_entry, t_exit
//  config  | cfg_we               | cfg_index, cfg_wdata
//
// One word per cycle in while busy is low, one result per word out: 3 front
// stages, the divider pipeline (prep, 8 stages of 4 quotient bits, saturate)
// and 3 merge/output stages lie between accept and out_valid. The divider
// stage loop sets the depth. Synchronous reset clears all valid bits and
// loads the register defaults; busy is set during reset and cleared once reset
// is released. The receiver cannot stall, so nothing ever holds the pipeline.

`include "ray_box_slab_test_unit_assert.svh"

module ray_box_slab_test_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [rbst_pkg::DIR_WIDTH-1:0]   in_dir_x,
  input  logic signed [rbst_pkg::DIR_WIDTH-1:0]   in_dir_y,
  input  logic signed [rbst_pkg::DIR_WIDTH-1:0]   in_dir_z,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] in_center_x,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] in_center_y,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] in_center_z,
  output logic out_valid,
  output logic out_hit,
  output logic [rbst_pkg::TLIM_W-1:0] out_t_entry,
  output logic [rbst_pkg::TLIM_W-1:0] out_t_exit,
  input  logic cfg_we,
  input  logic [rbst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbst_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int CW = rbst_pkg::COORD_WIDTH;
  localparam int DW = rbst_pkg::DIR_WIDTH;
  localparam int LW = rbst_pkg::LH_W;
  localparam int NW = rbst_pkg::NUM_W;
  localparam int TW = rbst_pkg::T_W;

  // config registers
  logic [rbst_pkg::HALF_W-1:0] half_r;
  logic [rbst_pkg::TLIM_W-1:0] tlim_r;
  logic [rbst_pkg::EPS_W-1:0]  eps_r;
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= rbst_pkg::HALF_RESET;
      tlim_r <= rbst_pkg::TLIM_RESET;
      eps_r  <= rbst_pkg::EPS_RESET;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          rbst_pkg::CFG_HALF_SIZE:    half_r <= cfg_wdata[rbst_pkg::HALF_W-1:0];
          rbst_pkg::CFG_T_LIMIT:      tlim_r <= cfg_wdata[rbst_pkg::TLIM_W-1:0];
          rbst_pkg::CFG_PARALLEL_EPS: eps_r  <= cfg_wdata[rbst_pkg::EPS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;
  logic acc;
  assign acc = start && !busy_r;

  // valid line
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, out_vld_r;
  logic dvld_r [0:rbst_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int k = 0; k < rbst_pkg::DIV_LAT; k++) dvld_r[k] <= 1'b0;
    end else begin
      s1_vld_r <= acc;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      dvld_r[0] <= s3_vld_r;
      for (int k = 1; k < rbst_pkg::DIV_LAT; k++) dvld_r[k] <= dvld_r[k-1];
      s4_vld_r  <= dvld_r[rbst_pkg::DIV_LAT-1];
      s5_vld_r  <= s4_vld_r;
      out_vld_r <= s5_vld_r;
    end
  end

  // stage 1: capture
  logic signed [CW-1:0] s1_o_r [3];
  logic signed [CW-1:0] s1_c_r [3];
  logic signed [DW-1:0] s1_d_r [3];

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_o_r[0] <= in_origin_x;  s1_o_r[1] <= in_origin_y;  s1_o_r[2] <= in_origin_z;
      s1_d_r[0] <= in_dir_x;     s1_d_r[1] <= in_dir_y;     s1_d_r[2] <= in_dir_z;
      s1_c_r[0] <= in_center_x;  s1_c_r[1] <= in_center_y;  s1_c_r[2] <= in_center_z;
    end
  end

  // stage 2: slab faces
  logic signed [LW-1:0] s2_lo_r [3];
  logic signed [LW-1:0] s2_hi_r [3];
  logic signed [LW-1:0] s2_o_r  [3];
  logic signed [DW-1:0] s2_d_r  [3];
  logic signed [LW-1:0] h_ext;

  assign h_ext = $signed({{(LW-rbst_pkg::HALF_W){1'b0}}, half_r});

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      s2_lo_r[a] <= $signed({{(LW-CW){s1_c_r[a][CW-1]}}, s1_c_r[a]}) - h_ext;
      s2_hi_r[a] <= $signed({{(LW-CW){s1_c_r[a][CW-1]}}, s1_c_r[a]}) + h_ext;
      s2_o_r[a]  <= $signed({{(LW-CW){s1_o_r[a][CW-1]}}, s1_o_r[a]});
      s2_d_r[a]  <= s1_d_r[a];
    end
  end

  // stage 3: numerators, parallel and outside flags
  logic signed [NW-1:0] s3_nlo_r [3];
  logic signed [NW-1:0] s3_nhi_r [3];
  logic signed [DW-1:0] s3_d_r   [3];
  rbst_pkg::side_t      s3_side_r;
  logic [DW-1:0]        dmag [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dmag[a] = s2_d_r[a][DW-1] ? DW'(-s2_d_r[a]) : DW'(s2_d_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      s3_nlo_r[a] <= $signed({s2_lo_r[a][LW-1], s2_lo_r[a]})
                   - $signed({s2_o_r[a][LW-1], s2_o_r[a]});
      s3_nhi_r[a] <= $signed({s2_hi_r[a][LW-1], s2_hi_r[a]})
                   - $signed({s2_o_r[a][LW-1], s2_o_r[a]});
      s3_d_r[a]   <= s2_d_r[a];
      s3_side_r.par[a] <= (s2_d_r[a] == '0)
                        || (dmag[a] < {{(DW-rbst_pkg::EPS_W){1'b0}}, eps_r});
      s3_side_r.outside[a] <= (s2_o_r[a] < s2_lo_r[a]) || (s2_o_r[a] > s2_hi_r[a]);
    end
  end

  // dividers, two per axis
  logic signed [TW-1:0] ta [3];
  logic signed [TW-1:0] tb [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbst_fx_div u_div_lo (.clk(clk), .in_num(s3_nlo_r[a]), .in_den(s3_d_r[a]), .out_t(ta[a]));
    rbst_fx_div u_div_hi (.clk(clk), .in_num(s3_nhi_r[a]), .in_den(s3_d_r[a]), .out_t(tb[a]));
  end

  // flags ride alongside the dividers
  rbst_pkg::side_t dside_r [0:rbst_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    dside_r[0] <= s3_side_r;
    for (int k = 1; k < rbst_pkg::DIV_LAT; k++) dside_r[k] <= dside_r[k-1];
  end

  // stage 4: order each axis; parallel axes pass the interval unchanged
  logic signed [TW-1:0] tlim_ext;
  logic signed [TW-1:0] s4_tn_r [3];
  logic signed [TW-1:0] s4_tf_r [3];
  logic                 s4_miss_r;
  rbst_pkg::side_t      dside_q;

  assign tlim_ext = $signed({{(TW-rbst_pkg::TLIM_W){1'b0}}, tlim_r});
  assign dside_q  = dside_r[rbst_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (dside_q.par[a]) begin
        s4_tn_r[a] <= '0;
        s4_tf_r[a] <= tlim_ext;
      end else if (ta[a] > tb[a]) begin
        s4_tn_r[a] <= tb[a];
        s4_tf_r[a] <= ta[a];
      end else begin
        s4_tn_r[a] <= ta[a];
        s4_tf_r[a] <= tb[a];
      end
    end
    s4_miss_r <= |(dside_q.par & dside_q.outside);
  end

  // stage 5: merge; the interval only narrows, so a final test is enough
  logic signed [TW-1:0] s5_tin_r, s5_tout_r;
  logic                 s5_miss_r;

  always_ff @(posedge clk) begin
    logic signed [TW-1:0] n_v, f_v;
    n_v = '0;
    f_v = tlim_ext;
    for (int a = 0; a < 3; a++) begin
      if (s4_tn_r[a] > n_v) n_v = s4_tn_r[a];
      if (s4_tf_r[a] < f_v) f_v = s4_tf_r[a];
    end
    s5_tin_r  <= n_v;
    s5_tout_r <= f_v;
    s5_miss_r <= s4_miss_r;
  end

  // stage 6: result word; a miss reports zeros
  logic                       hit_r;
  logic [rbst_pkg::TLIM_W-1:0] tent_r, texit_r;
  logic                       hit_nxt;

  assign hit_nxt = !s5_miss_r && (s5_tin_r <= s5_tout_r);

  always_ff @(posedge clk) begin
    hit_r   <= hit_nxt;
    tent_r  <= hit_nxt ? s5_tin_r[rbst_pkg::TLIM_W-1:0]  : '0;
    texit_r <= hit_nxt ? s5_tout_r[rbst_pkg::TLIM_W-1:0] : '0;
  end

  assign out_valid   = out_vld_r;
  assign out_hit     = hit_r;
  assign out_t_entry = tent_r;
  assign out_t_exit  = texit_r;

  `RBST_ASSERT_IMP(a_miss_zero, out_vld_r && !hit_r, (tent_r == '0) && (texit_r == '0))
  `RBST_ASSERT_IMP(a_entry_le_exit, out_vld_r && hit_r, tent_r <= texit_r)
  `RBST_ASSERT_IMP(a_exit_le_limit, out_vld_r && hit_r, texit_r <= tlim_r)
  `RBST_ASSERT_NXT(a_accept_tracked, acc, s1_vld_r)

endmodule

>>> tb/tb_ray_box_slab_test_unit.sv
// Self-checking testbench for ray_box_slab_test_unit: directed table, then random rays.
// Depends on rbst_pkg and the unit's RTL; results checked against a local fixed-point model.
`timescale 1ns / 1ps

module tb_ray_box_slab_test_unit;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int N_RANDOM = 500;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // one ray query and one result
  typedef struct {
    logic signed [rbst_pkg::COORD_WIDTH-1:0] org[3];
    logic signed [rbst_pkg::DIR_WIDTH-1:0]   dir[3];
    logic signed [rbst_pkg::COORD_WIDTH-1:0] ctr[3];
  } ray_word_t;

  typedef struct packed {
    logic                        hit;
    logic [rbst_pkg::TLIM_W-1:0] t_entry;
    logic [rbst_pkg::TLIM_W-1:0] t_exit;
  } slab_res_t;

  // directed row: either a register write or a word, with an optional typed result
  typedef struct {
    bit                             is_cfg;
    logic [rbst_pkg::CFG_IDX_W-1:0] idx;
    logic [rbst_pkg::CFG_W-1:0]     val;
    ray_word_t                      w;
    bit                             pin;
    slab_res_t                      res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [rbst_pkg::COORD_WIDTH-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [rbst_pkg::DIR_WIDTH-1:0]   in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [rbst_pkg::COORD_WIDTH-1:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic out_valid, out_hit;
  logic [rbst_pkg::TLIM_W-1:0] out_t_entry, out_t_exit;
  logic cfg_we = 1'b0;
  logic [rbst_pkg::CFG_IDX_W-1:0] cfg_index = rbst_pkg::CFG_HALF_SIZE;
  logic [rbst_pkg::CFG_W-1:0] cfg_wdata = '0;

  ray_box_slab_test_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_center_x(in_center_x), .in_center_y(in_center_y), .in_center_z(in_center_z),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_t_entry(out_t_entry), .out_t_exit(out_t_exit),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // local copy of the register file, tracked from the write port
  logic [rbst_pkg::HALF_W-1:0] box_half;
  logic [rbst_pkg::TLIM_W-1:0] far_limit;
  logic [rbst_pkg::EPS_W-1:0]  par_eps;

  slab_res_t pending_q[$];   // results still owed by the unit
  slab_res_t pinned_res;     // typed result for the current directed word
  bit        pinned_on = 1'b0;
  int        n_err = 0, n_words = 0, n_results = 0, n_hits = 0, n_cfg = 0;
  int        cycle = 0;

  // (num << FRAC_BITS) / den, truncated toward zero, saturated to 32 bits
  function automatic longint slab_quot(longint num, longint den);
    bit neg;
    longint unsigned mag, dmag, q;
    neg  = (num < 0) != (den < 0);
    mag  = (num < 0) ? -num : num;
    dmag = (den < 0) ? -den : den;
    if (mag >= (64'd1 << (62 - rbst_pkg::FRAC_BITS))) return neg ? SAT_LO : SAT_HI;
    q = (mag << rbst_pkg::FRAC_BITS) / dmag;
    if (neg) return (q > 64'h8000_0000) ? SAT_LO : -longint'(q);
    return (q > 64'h7FFF_FFFF) ? SAT_HI : longint'(q);
  endfunction

  // slab test over x, y, z with the current register values
  function automatic slab_res_t slab_predict(ray_word_t w);
    longint t_in, t_out, h, o, d, lo, hi, t1, t2, sw;
    bit hit;
    slab_res_t r;
    t_in = 0;
    t_out = longint'(far_limit);
    h = longint'(box_half);
    hit = 1'b1;
    for (int a = 0; a < 3 && hit; a++) begin
      o = w.org[a];
      d = w.dir[a];
      lo = longint'(w.ctr[a]) - h;
      hi = longint'(w.ctr[a]) + h;
      if (d == 0 || ((d < 0) ? -d : d) < longint'(par_eps)) begin
        if (o < lo || o > hi) hit = 1'b0;
      end else begin
        t1 = slab_quot(lo - o, d);
        t2 = slab_quot(hi - o, d);
        if (t1 > t2) begin
          sw = t1; t1 = t2; t2 = sw;
        end
        if (t1 > t_in) t_in = t1;
        if (t2 < t_out) t_out = t2;
        if (t_in > t_out) hit = 1'b0;
      end
    end
    r.hit = hit;
    r.t_entry = hit ? t_in[rbst_pkg::TLIM_W-1:0] : '0;
    r.t_exit  = hit ? t_out[rbst_pkg::TLIM_W-1:0] : '0;
    return r;
  endfunction

  function automatic ray_word_t mk_word(longint ox, longint oy, longint oz,
                                        longint dx, longint dy, longint dz,
                                        longint cx, longint cy, longint cz);
    ray_word_t w;
    w.org[0] = ox; w.org[1] = oy; w.org[2] = oz;
    w.dir[0] = dx; w.dir[1] = dy; w.dir[2] = dz;
    w.ctr[0] = cx; w.ctr[1] = cy; w.ctr[2] = cz;
    return w;
  endfunction

  // Monitor: register writes, accepted words and results, all on the rising edge.
  // Compare before push so a same-edge accept never meets its own expectation.
  always @(posedge clk) begin
    slab_res_t got, want;
    cycle <= cycle + 1;
    if (!rst_n) begin
      box_half  = rbst_pkg::HALF_RESET;
      far_limit = rbst_pkg::TLIM_RESET;
      par_eps   = rbst_pkg::EPS_RESET;
    end else begin
      if (out_valid) begin
        got = '{out_hit, out_t_entry, out_t_exit};
        n_results++;
        if (out_hit) n_hits++;
        if (pending_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("ERROR: result with nothing pending: %0b %0d %0d",
                                    got.hit, got.t_entry, got.t_exit);
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 10)
              $display("ERROR: hit/entry/exit exp %0b %0d %0d got %0b %0d %0d",
                       want.hit, want.t_entry, want.t_exit,
                       got.hit, got.t_entry, got.t_exit);
          end
        end
      end
      if (start && !busy) begin
        if (pinned_on) pending_q.push_back(pinned_res);
        else pending_q.push_back(slab_predict(mk_word(
          in_origin_x, in_origin_y, in_origin_z, in_dir_x, in_dir_y, in_dir_z,
          in_center_x, in_center_y, in_center_z)));
      end
      // config only changes while idle, so updating after the predict is safe
      if (cfg_we) begin
        case (cfg_index)
          rbst_pkg::CFG_HALF_SIZE:    box_half  = cfg_wdata[rbst_pkg::HALF_W-1:0];
          rbst_pkg::CFG_T_LIMIT:      far_limit = cfg_wdata[rbst_pkg::TLIM_W-1:0];
          rbst_pkg::CFG_PARALLEL_EPS: par_eps   = cfg_wdata[rbst_pkg::EPS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    if (cycle >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle, pending_q.size());
      $display("FAIL ray_box_slab_test_unit");
      $finish;
    end
  end

  // Present one word from the falling edge; hold start until accepted
  task automatic send_word(ray_word_t w, bit pin, slab_res_t res);
    @(negedge clk);
    start <= 1'b1;
    {in_origin_x, in_origin_y, in_origin_z} <= {w.org[0], w.org[1], w.org[2]};
    {in_dir_x, in_dir_y, in_dir_z} <= {w.dir[0], w.dir[1], w.dir[2]};
    {in_center_x, in_center_y, in_center_z} <= {w.ctr[0], w.ctr[1], w.ctr[2]};
    pinned_on = pin;
    pinned_res = res;
    do @(posedge clk); while (busy);
    n_words++;
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop issuing, then write a register once the pipe has drained
  task automatic write_reg(logic [rbst_pkg::CFG_IDX_W-1:0] idx,
                           logic [rbst_pkg::CFG_W-1:0] val);
    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  // Random ray: mostly aimed near the box, some wild noise
  function automatic ray_word_t rand_ray();
    ray_word_t w;
    int kind;
    longint tt;
    kind = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      if (kind == 0) begin
        w.org[a] = $urandom; w.ctr[a] = $urandom; w.dir[a] = $urandom;
      end else begin
        w.dir[a] = (kind == 1) ? $urandom : longint'($urandom_range(0, 131072)) - 65536;
        if ($urandom_range(0, 7) == 0) w.dir[a] = $urandom_range(0, 3) - 1;
        w.ctr[a] = longint'($urandom_range(0, 2097152)) - 1048576;
        if (kind == 2) w.ctr[a] = $urandom;
        tt = $urandom_range(0, 4194304);
        // back off along the ray so it tends to pass through the centre
        w.org[a] = longint'(w.ctr[a]) - ((longint'(w.dir[a]) * tt) >>> rbst_pkg::FRAC_BITS)
                   + longint'($urandom_range(0, 65536)) - 32768;
      end
    end
    return w;
  endfunction

  task automatic rand_cfg();
    logic [rbst_pkg::CFG_W-1:0] hs, tl, ep;
    case ($urandom_range(0, 3))
      0: hs = $urandom_range(0, 65536);
      1: hs = $urandom_range(0, 32'h7FFF_FFFF);
      default: hs = $urandom_range(1024, 1048576);
    endcase
    tl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                     : $urandom_range(0, 67108864);
    ep = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65536) : $urandom_range(0, 64);
    write_reg(rbst_pkg::CFG_HALF_SIZE, hs);
    write_reg(rbst_pkg::CFG_T_LIMIT, tl);
    write_reg(rbst_pkg::CFG_PARALLEL_EPS, ep);
  endtask

  row_t rows[$];

  function automatic row_t wrow(ray_word_t w, bit pin, slab_res_t res);
    row_t r;
    r.is_cfg = 1'b0; r.idx = rbst_pkg::CFG_HALF_SIZE; r.val = '0;
    r.w = w; r.pin = pin; r.res = res;
    return r;
  endfunction

  function automatic row_t crow(logic [rbst_pkg::CFG_IDX_W-1:0] idx,
                                logic [rbst_pkg::CFG_W-1:0] val);
    row_t r;
    r.is_cfg = 1'b1; r.idx = idx; r.val = val;
    r.w = mk_word(0, 0, 0, 0, 0, 0, 0, 0, 0); r.pin = 1'b0; r.res = '0;
    return r;
  endfunction

  function automatic void build_table();
    slab_res_t nr;
    nr = '0;
    // defaults: half 0.5, limit 1000, eps 1 ulp
    rows.push_back(wrow(mk_word(0, 0, 0, 65536, 0, 0, 0, 0, 0), 1, '{1'b1, 31'd0, 31'd32768}));
    // parallel axis with origin outside its slab: miss reports zeros
    rows.push_back(wrow(mk_word(0, 65536, 0, 65536, 0, 0, 0, 0, 0), 1, '0));
    // origin exactly on a face counts as inside
    rows.push_back(wrow(mk_word(0, 32768, -32768, 65536, 0, 0, 0, 0, 0), 1,
                        '{1'b1, 31'd0, 31'd32768}));
    // no direction at all: origin inside keeps [0, limit], origin outside misses
    rows.push_back(wrow(mk_word(7, -7, 0, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 31'd0, 31'd65536000}));
    rows.push_back(wrow(mk_word(0, 0, 32769, 0, 0, 0, 0, 0, 0), 1, nr));
    // box ahead on x
    rows.push_back(wrow(mk_word(-131072, 0, 0, 65536, 0, 0, 0, 0, 0), 1,
                        '{1'b1, 31'd98304, 31'd163840}));
    // box behind: pointing away
    rows.push_back(wrow(mk_word(-131072, 0, 0, -65536, 0, 0, 0, 0, 0), 1, nr));
    // tiny direction: quotients saturate
    rows.push_back(wrow(mk_word(0, 0, 0, 1, -1, 1, 0, 0, 0), 0, nr));
    // rounding toward zero with odd divisors
    rows.push_back(wrow(mk_word(-100000, 3, -5, 3, -7, 65535, 1, 0, 0), 0, nr));
    // field extremes, out-of-range directions
    rows.push_back(wrow(mk_word(2147483647, 2147483647, 2147483647, 131071, 131071, 131071,
                                -2147483648, -2147483648, -2147483648), 0, nr));
    rows.push_back(wrow(mk_word(-2147483648, -2147483648, -2147483648,
                                -131072, -131072, -131072,
                                2147483647, 2147483647, 2147483647), 0, nr));
    rows.push_back(wrow(mk_word(-2147483648, 0, 2147483647, -65536, 65536, -1,
                                -2147483648, 0, 2147483647), 0, nr));
    // zero half size: entry equals exit, still a hit
    rows.push_back(crow(rbst_pkg::CFG_HALF_SIZE, 31'd0));
    rows.push_back(wrow(mk_word(-65536, 0, 0, 65536, 0, 0, 0, 0, 0), 1,
                        '{1'b1, 31'd65536, 31'd65536}));
    // zero epsilon: a zero direction still counts as parallel
    rows.push_back(crow(rbst_pkg::CFG_PARALLEL_EPS, 31'd0));
    rows.push_back(wrow(mk_word(0, 0, 0, 0, 0, 1, 0, 0, 0), 0, nr));
    // zero limit
    rows.push_back(crow(rbst_pkg::CFG_T_LIMIT, 31'd0));
    rows.push_back(wrow(mk_word(-65536, 0, 0, 65536, 0, 0, 0, 0, 0), 1, nr));
    rows.push_back(wrow(mk_word(0, 0, 0, 65536, 0, 0, 0, 0, 0), 0, nr));
    // largest settings
    rows.push_back(crow(rbst_pkg::CFG_HALF_SIZE, 31'h7FFF_FFFF));
    rows.push_back(crow(rbst_pkg::CFG_T_LIMIT, 31'h7FFF_FFFF));
    rows.push_back(crow(rbst_pkg::CFG_PARALLEL_EPS, 31'd65536));
    rows.push_back(wrow(mk_word(-2147483648, 2147483647, 0, 65535, -65536, 65536,
                                2147483647, -2147483648, 0), 0, nr));
    rows.push_back(wrow(mk_word(5, 5, 5, 65536, 65536, -65536, 0, 0, 0), 0, nr));
  endfunction

  initial begin
    build_table();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
      else send_word(rows[i].w, rows[i].pin, rows[i].res);
    end
    @(negedge clk);
    start <= 1'b0;
    pinned_on = 1'b0;

    // random phases, each under a fresh register setting; the last stretch has no gaps
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        write_reg(rbst_pkg::CFG_HALF_SIZE, rbst_pkg::HALF_RESET);
        write_reg(rbst_pkg::CFG_T_LIMIT, rbst_pkg::TLIM_RESET);
        write_reg(rbst_pkg::CFG_PARALLEL_EPS, rbst_pkg::EPS_RESET);
      end else rand_cfg();
      for (int k = 0; k < N_RANDOM / 8; k++) begin
        if (p < 6 && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 9));
        send_word(rand_ray(), 1'b0, '0);
      end
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (rbst_pkg::DIV_LAT + 10) @(posedge clk);

    $display("covered %0d words (%0d hits) over %0d register writes", n_words, n_hits, n_cfg);
    $display("%0d results seen, %0d mismatches", n_results, n_err);
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("PASS ray_box_slab_test_unit");
    end else begin
      $display("FAIL ray_box_slab_test_unit");
    end
    $finish;
  end

endmodule
